### rtl/avrf_pkg.sv
// avrf_pkg: shared types, constants and the arctangent table of the relevance filter
package avrf_pkg;

  localparam int ATAN_LEN    = 24;
  localparam int SQRT_STEPS  = 24;
  localparam int DIV_STEPS   = 48;
  localparam int ROBOT_PRODS = 10;
  localparam int QUERY_PRODS = 4;
  localparam int NPROD       = 11;
  localparam int CNT_W       = 6;
  localparam logic [23:0] TWO_METRES = 24'd2048;

  localparam logic OP_ROBOT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [3:0] mul_sel_t;
  // robot update products
  localparam mul_sel_t MS_WW  = 4'd0;
  localparam mul_sel_t MS_XX  = 4'd1;
  localparam mul_sel_t MS_YY  = 4'd2;
  localparam mul_sel_t MS_ZZ  = 4'd3;
  localparam mul_sel_t MS_XZ  = 4'd4;
  localparam mul_sel_t MS_WY  = 4'd5;
  localparam mul_sel_t MS_XY  = 4'd6;
  localparam mul_sel_t MS_WZ  = 4'd7;
  localparam mul_sel_t MS_VXX = 4'd8;
  localparam mul_sel_t MS_VYY = 4'd9;
  localparam mul_sel_t MS_NUM = 4'd10;
  // agent query products
  localparam mul_sel_t MS_DXX = 4'd0;
  localparam mul_sel_t MS_DYY = 4'd1;
  localparam mul_sel_t MS_NRR = 4'd2;
  localparam mul_sel_t MS_VDD = 4'd3;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CHECK_ENABLE      = 3'd0;
  localparam cfg_idx_t CFG_VIEW_DISTANCE_MAX = 3'd1;
  localparam cfg_idx_t CFG_VIEW_DISTANCE_MIN = 3'd2;
  localparam cfg_idx_t CFG_SPEED_THRESHOLD   = 3'd3;
  localparam cfg_idx_t CFG_VIEW_HALF_ANGLE   = 3'd4;
  localparam cfg_idx_t CFG_MAPPING_RANGE     = 3'd5;

  typedef struct packed {
    logic              operation;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } avrf_in_t;

  typedef struct packed {
    logic        in_view;
    logic        near_robot;
    logic        robot_known;
    logic [22:0] view_distance;
  } avrf_out_t;

  typedef struct packed {
    logic             load;
    logic             mul_en;
    mul_sel_t         mul_sel;
    logic             cord_init;
    logic             cord_step;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             finish;
    logic [CNT_W-1:0] step;
  } avrf_cmd_t;

  typedef struct packed {
    logic op;
    logic out_busy;
  } avrf_sts_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335088;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/avrf_chan_if.sv
// avrf_chan_if: valid/ready channel carrying one word of type T
interface avrf_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/avrf_dp.sv
// avrf_dp: datapath with shared multiplier, cordic, square root, divider and result register
module avrf_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  avrf_pkg::avrf_cmd_t   cmd,
  output avrf_pkg::avrf_sts_t   sts,
  input  avrf_pkg::avrf_in_t    in_data,
  input  logic                  cfg_write,
  input  avrf_pkg::cfg_idx_t    cfg_index,
  input  logic [22:0]           cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output avrf_pkg::avrf_out_t   out_data
);

  // configuration
  logic        check_enable;
  logic [22:0] vd_max, vd_min, map_range;
  logic [14:0] thr;
  logic [15:0] half_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= 1'b0;
      vd_max       <= 23'd6144;
      vd_min       <= 23'd1536;
      thr          <= 15'd307;
      half_angle   <= 16'd16368;
      map_range    <= 23'd5120;
    end else if (cfg_write) begin
      unique case (cfg_index)
        avrf_pkg::CFG_CHECK_ENABLE:      check_enable <= cfg_data[0];
        avrf_pkg::CFG_VIEW_DISTANCE_MAX: vd_max       <= cfg_data;
        avrf_pkg::CFG_VIEW_DISTANCE_MIN: vd_min       <= cfg_data;
        avrf_pkg::CFG_SPEED_THRESHOLD:   thr          <= cfg_data[14:0];
        avrf_pkg::CFG_VIEW_HALF_ANGLE:   half_angle   <= cfg_data[15:0];
        avrf_pkg::CFG_MAPPING_RANGE:     map_range    <= cfg_data;
        default: ;
      endcase
    end
  end

  // robot state
  logic signed [23:0] robot_x, robot_y;
  logic [15:0]        heading;
  logic [22:0]        cur_vd;
  logic               have_robot;

  // captured word
  logic               op;
  logic signed [23:0] px, py;
  logic signed [15:0] qx, qy, qz, qw, vx, vy;
  logic signed [24:0] dx, dy;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_data.operation;
      px <= in_data.pos_x;
      py <= in_data.pos_y;
      qx <= in_data.quat_x;
      qy <= in_data.quat_y;
      qz <= in_data.quat_z;
      qw <= in_data.quat_w;
      vx <= in_data.vel_x;
      vy <= in_data.vel_y;
      dx <= 25'(in_data.pos_x) - 25'(robot_x);
      dy <= 25'(in_data.pos_y) - 25'(robot_y);
    end
  end

  // shared multiplier
  logic signed [25:0] ma, mb;
  logic signed [51:0] prod [avrf_pkg::NPROD];
  logic [24:0]        speed;
  logic [23:0]        near_lim;

  assign near_lim = 24'(map_range) + avrf_pkg::TWO_METRES;

  always_comb begin
    ma = '0;
    mb = '0;
    if (op == avrf_pkg::OP_QUERY) begin
      unique case (cmd.mul_sel)
        avrf_pkg::MS_DXX: begin ma = 26'(dx); mb = 26'(dx); end
        avrf_pkg::MS_DYY: begin ma = 26'(dy); mb = 26'(dy); end
        avrf_pkg::MS_NRR: begin ma = {2'b00, near_lim}; mb = {2'b00, near_lim}; end
        avrf_pkg::MS_VDD: begin ma = {3'b000, cur_vd}; mb = {3'b000, cur_vd}; end
        default: ;
      endcase
    end else begin
      unique case (cmd.mul_sel)
        avrf_pkg::MS_WW:  begin ma = 26'(qw); mb = 26'(qw); end
        avrf_pkg::MS_XX:  begin ma = 26'(qx); mb = 26'(qx); end
        avrf_pkg::MS_YY:  begin ma = 26'(qy); mb = 26'(qy); end
        avrf_pkg::MS_ZZ:  begin ma = 26'(qz); mb = 26'(qz); end
        avrf_pkg::MS_XZ:  begin ma = 26'(qx); mb = 26'(qz); end
        avrf_pkg::MS_WY:  begin ma = 26'(qw); mb = 26'(qy); end
        avrf_pkg::MS_XY:  begin ma = 26'(qx); mb = 26'(qy); end
        avrf_pkg::MS_WZ:  begin ma = 26'(qw); mb = 26'(qz); end
        avrf_pkg::MS_VXX: begin ma = 26'(vx); mb = 26'(vx); end
        avrf_pkg::MS_VYY: begin ma = 26'(vy); mb = 26'(vy); end
        avrf_pkg::MS_NUM: begin ma = {3'b000, vd_max}; mb = {1'b0, speed}; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod[cmd.mul_sel] <= ma * mb;
  end

  // cordic vectoring
  logic signed [33:0] x0, y0;
  logic signed [49:0] xs0, ys0, cx, cy, shx, shy;
  logic [31:0]        cz, cz_rnd, at;
  logic               czero;
  logic [15:0]        angle;

  always_comb begin
    if (op == avrf_pkg::OP_QUERY) begin
      x0 = 34'(dx);
      y0 = 34'(dy);
    end else begin
      x0 = 34'(prod[avrf_pkg::MS_WW]) + 34'(prod[avrf_pkg::MS_XX])
         - 34'(prod[avrf_pkg::MS_YY]) - 34'(prod[avrf_pkg::MS_ZZ]);
      y0 = (34'(prod[avrf_pkg::MS_XY]) + 34'(prod[avrf_pkg::MS_WZ])) <<< 1;
    end
    xs0 = $signed({x0, 16'h0000});
    ys0 = $signed({y0, 16'h0000});
    shx = cx >>> cmd.step[4:0];
    shy = cy >>> cmd.step[4:0];
    at  = avrf_pkg::atan_val(cmd.step[4:0]);
    cz_rnd = cz + 32'h0000_8000;
    angle  = czero ? 16'h0000 : cz_rnd[31:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      czero <= (x0 == '0) && (y0 == '0);
      if (xs0 < 0) begin
        cx <= -xs0;
        cy <= -ys0;
        cz <= 32'h8000_0000;
      end else begin
        cx <= xs0;
        cy <= ys0;
        cz <= 32'h0000_0000;
      end
    end else if (cmd.cord_step) begin
      if (cy > 0) begin
        cx <= cx + shy;
        cy <= cy - shx;
        cz <= cz + at;
      end else begin
        cx <= cx - shy;
        cy <= cy + shx;
        cz <= cz - at;
      end
    end
  end

  // bit-pair square root of speed squared
  logic [47:0] sv, sr, sb, st;
  logic [31:0] vsum;

  assign vsum  = 32'(prod[avrf_pkg::MS_VXX]) + 32'(prod[avrf_pkg::MS_VYY]);
  assign st    = sr + sb;
  assign speed = sr[24:0];

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sv <= {vsum, 16'h0000};
      sr <= '0;
      sb <= 48'h4000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (sv >= st) begin
        sv <= sv - st;
        sr <= (sr >> 1) + sb;
      end else begin
        sr <= sr >> 1;
      end
      sb <= sb >> 2;
    end
  end

  // restoring divider
  logic [47:0] dnum;
  logic [22:0] drem, dden;
  logic [23:0] dt;

  assign dden = {thr, 8'h00};
  assign dt   = {drem, dnum[47]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dnum <= 48'(prod[avrf_pkg::MS_NUM]);
      drem <= '0;
    end else if (cmd.div_step) begin
      if (dt >= {1'b0, dden}) begin
        drem <= 23'(dt - {1'b0, dden});
        dnum <= {dnum[46:0], 1'b1};
      end else begin
        drem <= dt[22:0];
        dnum <= {dnum[46:0], 1'b0};
      end
    end
  end

  // finishing logic
  logic [47:0]        raw;
  logic [22:0]        new_vd;
  logic signed [33:0] qnorm;
  logic signed [33:0] gdiff, gabs;
  logic               gimbal;
  logic [50:0]        d2, nr2, vd2;
  logic [15:0]        diff;
  logic [16:0]        err;
  logic               q_in, q_near;
  avrf_pkg::avrf_out_t res;

  always_comb begin
    raw = (thr == '0) ? {25'd0, vd_max} : dnum;
    if (raw < {25'd0, vd_min}) new_vd = vd_min;
    else if (raw > {25'd0, vd_max}) new_vd = vd_max;
    else new_vd = raw[22:0];

    // four full-scale squares reach 2^32
    qnorm = 34'(prod[avrf_pkg::MS_WW]) + 34'(prod[avrf_pkg::MS_XX])
          + 34'(prod[avrf_pkg::MS_YY]) + 34'(prod[avrf_pkg::MS_ZZ]);
    gdiff = (34'(prod[avrf_pkg::MS_XZ]) - 34'(prod[avrf_pkg::MS_WY])) <<< 1;
    gabs  = (gdiff < 0) ? -gdiff : gdiff;
    gimbal = gabs >= qnorm;

    d2  = prod[avrf_pkg::MS_DXX][50:0] + prod[avrf_pkg::MS_DYY][50:0];
    nr2 = prod[avrf_pkg::MS_NRR][50:0];
    vd2 = prod[avrf_pkg::MS_VDD][50:0];
    diff = angle - heading;
    err  = (diff <= 16'h8000) ? {1'b0, diff} : 17'h10000 - {1'b0, diff};
    q_near = d2 < nr2;
    q_in   = (d2 <= vd2) && (err < {1'b0, half_angle});

    res.view_distance = cur_vd;
    res.robot_known   = have_robot;
    res.in_view       = 1'b0;
    res.near_robot    = 1'b0;
    if (op == avrf_pkg::OP_ROBOT) begin
      res.view_distance = new_vd;
      res.robot_known   = 1'b1;
    end else if (have_robot) begin
      if (!check_enable) begin
        res.in_view = 1'b1;
      end else begin
        res.in_view    = q_in;
        res.near_robot = q_near;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      robot_x    <= '0;
      robot_y    <= '0;
      heading    <= '0;
      cur_vd     <= '0;
      have_robot <= 1'b0;
    end else if (cmd.finish && op == avrf_pkg::OP_ROBOT) begin
      robot_x    <= px;
      robot_y    <= py;
      heading    <= gimbal ? 16'h0000 : angle;
      cur_vd     <= new_vd;
      have_robot <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data <= res;
  end

  assign sts.op       = op;
  assign sts.out_busy = out_valid & ~out_ready;

endmodule

### rtl/avrf_ctrl.sv
// avrf_ctrl: sequencer that steps the datapath through one update or query
module avrf_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  avrf_pkg::avrf_sts_t sts,
  output avrf_pkg::avrf_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_MUL       = 10'b0000000010,
    S_CORD_INIT = 10'b0000000100,
    S_CORD      = 10'b0000001000,
    S_SQRT_INIT = 10'b0000010000,
    S_SQRT      = 10'b0000100000,
    S_PROD      = 10'b0001000000,
    S_DIV_INIT  = 10'b0010000000,
    S_DIV       = 10'b0100000000,
    S_FIN       = 10'b1000000000
  } state_t;

  localparam logic [avrf_pkg::CNT_W-1:0] CORD_LAST  = avrf_pkg::CNT_W'(CORDIC_STEPS - 1);
  localparam logic [avrf_pkg::CNT_W-1:0] SQRT_LAST  = avrf_pkg::CNT_W'(avrf_pkg::SQRT_STEPS - 1);
  localparam logic [avrf_pkg::CNT_W-1:0] DIV_LAST   = avrf_pkg::CNT_W'(avrf_pkg::DIV_STEPS - 1);
  localparam logic [avrf_pkg::CNT_W-1:0] ROBOT_LAST = avrf_pkg::CNT_W'(avrf_pkg::ROBOT_PRODS - 1);
  localparam logic [avrf_pkg::CNT_W-1:0] QUERY_LAST = avrf_pkg::CNT_W'(avrf_pkg::QUERY_PRODS - 1);

  state_t                     state, state_next;
  logic [avrf_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                       last;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    last       = 1'b0;
    cmd        = '0;
    cmd.step   = cnt;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cnt[3:0];
        last = (sts.op == avrf_pkg::OP_QUERY) ? (cnt == QUERY_LAST) : (cnt == ROBOT_LAST);
        if (last) state_next = S_CORD_INIT;
      end
      S_CORD_INIT: begin
        cmd.cord_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (cnt == CORD_LAST) begin
          state_next = (sts.op == avrf_pkg::OP_QUERY) ? S_FIN : S_SQRT_INIT;
        end
      end
      S_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == SQRT_LAST) state_next = S_PROD;
      end
      S_PROD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = avrf_pkg::MS_NUM;
        state_next  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // a result never overwrites one still waiting
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_busy) else $error("finish while result pending");

  // a finished word is offered next cycle
  a_fin_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> sts.out_busy || $past(cmd.finish)) else $error("result not offered");

  // product index stays inside the product table
  a_mul_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (cnt <= ROBOT_LAST)) else $error("product index out of range");

  // cordic step index stays inside the angle table
  a_cord_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORD) |-> (cnt <= CORD_LAST)) else $error("cordic step out of range");

endmodule

### rtl/agent_view_relevance_filter_unit.sv
// agent_view_relevance_filter_unit: top level of the agent view relevance filter
// Takes one word at a time and returns one result word for each. An agent query
// goes through four products on the shared multiplier and the bearing cordic; a
// robot update goes through ten products, the yaw cordic, a 24-step square root,
// one more product and a 48-step divider. A finished result waits in an output
// register, and the next word is taken while it waits. CORDIC_STEPS ranges from
// 8 to 24.
module agent_view_relevance_filter_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  avrf_chan_if.sink          req,
  avrf_chan_if.source        rsp,
  input  logic               cfg_write,
  input  avrf_pkg::cfg_idx_t cfg_index,
  input  logic [22:0]        cfg_data
);

  avrf_pkg::avrf_cmd_t cmd;
  avrf_pkg::avrf_sts_t sts;

  avrf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  avrf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (req.data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data)
  );

endmodule

### sim/agent_view_relevance_filter_unit_tb.sv
// agent_view_relevance_filter_unit_tb: checks the relevance filter against an in-bench predictor
module agent_view_relevance_filter_unit_tb;

  localparam int STEPS = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 110;

  logic clk;
  logic rst;
  logic cfg_write;
  avrf_pkg::cfg_idx_t cfg_index;
  logic [22:0] cfg_data;

  avrf_chan_if #(.T(avrf_pkg::avrf_in_t)) req_ch ();
  avrf_chan_if #(.T(avrf_pkg::avrf_out_t)) rsp_ch ();

  agent_view_relevance_filter_unit #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // arctangent of 2^-i, 2^32 per turn
  logic [31:0] arctan_step [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335088,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

  // predictor copy of registers and pose
  logic        m_check;
  logic [22:0] m_vmax, m_vmin, m_map;
  logic [14:0] m_thr;
  logic [15:0] m_half;
  logic signed [23:0] pose_x, pose_y;
  logic [15:0] pose_yaw;
  logic [22:0] pose_vd;
  logic        pose_valid;

  typedef struct {
    avrf_pkg::avrf_in_t  item;
    bit                  typed;
    avrf_pkg::avrf_out_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];
  avrf_pkg::avrf_out_t due_results[$];
  int errors;
  int idle_cycles;
  int burst_left;
  int ready_pct;
  int ready_cnt;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] bearing_angle(input longint y, input longint x);
    longint xs, ys, sx, sy;
    logic [31:0] z;
    logic [31:0] t;
    if (x == 0 && y == 0) return 16'd0;
    xs = x * 65536;
    ys = y * 65536;
    z = 32'd0;
    if (xs < 0) begin
      xs = -xs;
      ys = -ys;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      sx = ys >>> i;
      sy = xs >>> i;
      if (ys > 0) begin
        xs += sx;
        ys -= sy;
        z += arctan_step[i];
      end else begin
        xs -= sx;
        ys += sy;
        z -= arctan_step[i];
      end
    end
    t = z + 32'h8000;
    return t[31:16];
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // advances the predicted pose and returns the expected result word
  function automatic avrf_pkg::avrf_out_t relevance_of(input avrf_pkg::avrf_in_t it);
    avrf_pkg::avrf_out_t o;
    longint qx, qy, qz, qw, vx, vy, d, g, dx, dy;
    longint unsigned spd, raw, d2, nr, vd;
    logic [15:0] diff;
    int err;
    o = '0;
    if (it.operation == avrf_pkg::OP_ROBOT) begin
      qx = it.quat_x; qy = it.quat_y; qz = it.quat_z; qw = it.quat_w;
      vx = it.vel_x; vy = it.vel_y;
      d = qw * qw + qx * qx + qy * qy + qz * qz;
      g = 2 * (qx * qz - qw * qy);
      if (g < 0) g = -g;
      if (g >= d) pose_yaw = 16'd0;
      else pose_yaw = bearing_angle(2 * (qx * qy + qw * qz),
                                    qw * qw + qx * qx - qy * qy - qz * qz);
      spd = int_sqrt(longint'(vx * vx + vy * vy) << 16);
      if (m_thr == 0) raw = m_vmax;
      else raw = (longint'(m_vmax) * spd) / (longint'(m_thr) << 8);
      if (raw < m_vmin) raw = m_vmin;
      else if (raw > m_vmax) raw = m_vmax;
      pose_vd = raw[22:0];
      pose_x = it.pos_x;
      pose_y = it.pos_y;
      pose_valid = 1'b1;
    end else if (pose_valid) begin
      if (!m_check) begin
        o.in_view = 1'b1;
      end else begin
        dx = longint'(it.pos_x) - longint'(pose_x);
        dy = longint'(it.pos_y) - longint'(pose_y);
        d2 = dx * dx + dy * dy;
        nr = longint'(m_map) + 2048;
        vd = pose_vd;
        o.near_robot = d2 < nr * nr;
        if (d2 <= vd * vd) begin
          diff = bearing_angle(dy, dx) - pose_yaw;
          err = (diff <= 16'd32768) ? int'(diff) : 65536 - int'(diff);
          o.in_view = err < int'(m_half);
        end
      end
    end
    o.robot_known = pose_valid;
    o.view_distance = pose_vd;
    return o;
  endfunction

  function automatic avrf_pkg::avrf_in_t make_item(input logic op, input int px, input int py,
      input int qx, input int qy, input int qz, input int qw, input int vx, input int vy);
    avrf_pkg::avrf_in_t it;
    it.operation = op;
    it.pos_x = 24'(px); it.pos_y = 24'(py);
    it.quat_x = 16'(qx); it.quat_y = 16'(qy); it.quat_z = 16'(qz); it.quat_w = 16'(qw);
    it.vel_x = 16'(vx); it.vel_y = 16'(vy);
    return it;
  endfunction

  function automatic void add_row(input avrf_pkg::avrf_in_t item, input bit typed,
      input avrf_pkg::avrf_out_t want);
    stim_row_t r;
    r.item = item;
    r.typed = typed;
    r.want = want;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic int srand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic avrf_pkg::avrf_in_t random_item();
    avrf_pkg::avrf_in_t it;
    int sel;
    it = make_item(avrf_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
    it.pos_x = 24'($urandom);
    it.pos_y = 24'($urandom);
    it.vel_x = 16'($urandom);
    it.vel_y = 16'($urandom);
    for (int k = 0; k < 4; k++) begin
      sel = srand(16384);
      if ($urandom_range(0, 9) == 0) sel = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
      case (k)
        0: it.quat_x = 16'(sel);
        1: it.quat_y = 16'(sel);
        2: it.quat_z = 16'(sel);
        default: it.quat_w = 16'(sel);
      endcase
    end
    if ($urandom_range(0, 99) < 30) begin
      it.operation = avrf_pkg::OP_ROBOT;
      if ($urandom_range(0, 1) != 0) begin
        it.vel_x = 16'(srand(400));
        it.vel_y = 16'(srand(400));
      end
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        it.pos_x = 24'(int'(pose_x) + srand(2 * int'(pose_vd) + 4096));
        it.pos_y = 24'(int'(pose_y) + srand(2 * int'(pose_vd) + 4096));
      end else if (sel == 7) begin
        // exactly on the view distance edge
        it.pos_x = 24'(int'(pose_x) +
                       (($urandom_range(0, 1) != 0) ? int'(pose_vd) : -int'(pose_vd)));
        it.pos_y = pose_y;
      end else if (sel == 8) begin
        it.pos_x = pose_x;
        it.pos_y = pose_y;
      end
    end
    return it;
  endfunction

  task automatic write_reg(input avrf_pkg::cfg_idx_t idx, input logic [22:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      avrf_pkg::CFG_CHECK_ENABLE:      m_check = val[0];
      avrf_pkg::CFG_VIEW_DISTANCE_MAX: m_vmax = val;
      avrf_pkg::CFG_VIEW_DISTANCE_MIN: m_vmin = val;
      avrf_pkg::CFG_SPEED_THRESHOLD:   m_thr = val[14:0];
      avrf_pkg::CFG_VIEW_HALF_ANGLE:   m_half = val[15:0];
      default:                         m_map = val;
    endcase
  endtask

  task automatic set_regs(input logic ce, input logic [22:0] vmax, input logic [22:0] vmin,
      input logic [22:0] thr, input logic [22:0] half, input logic [22:0] map);
    req_ch.valid <= 1'b0;
    wait (due_results.size() == 0);
    @(negedge clk);
    write_reg(avrf_pkg::CFG_CHECK_ENABLE, {22'd0, ce});
    write_reg(avrf_pkg::CFG_VIEW_DISTANCE_MAX, vmax);
    write_reg(avrf_pkg::CFG_VIEW_DISTANCE_MIN, vmin);
    write_reg(avrf_pkg::CFG_SPEED_THRESHOLD, thr);
    write_reg(avrf_pkg::CFG_VIEW_HALF_ANGLE, half);
    write_reg(avrf_pkg::CFG_MAPPING_RANGE, map);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input avrf_pkg::avrf_in_t it, input bit typed,
      input avrf_pkg::avrf_out_t want);
    avrf_pkg::avrf_out_t pred;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pred = relevance_of(it);
    due_results.insert(due_results.size(), typed ? want : pred);
    burst_left--;
    @(negedge clk);
  endtask

  // receiver stall pattern: ready is drawn against a duty of 100, 70, 40 or 10 percent, redrawn periodically
  always @(negedge clk) begin
    ready_cnt <= ready_cnt + 1;
    if (ready_cnt % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 70;
        2: ready_pct <= 40;
        default: ready_pct <= 10;
      endcase
    end
    rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin
    avrf_pkg::avrf_out_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (got.in_view !== want.in_view) begin
          $display("%0t: in_view expected %b actual %b", $time, want.in_view, got.in_view);
          errors++;
        end
        if (got.near_robot !== want.near_robot) begin
          $display("%0t: near_robot expected %b actual %b", $time, want.near_robot,
                   got.near_robot);
          errors++;
        end
        if (got.robot_known !== want.robot_known) begin
          $display("%0t: robot_known expected %b actual %b", $time, want.robot_known,
                   got.robot_known);
          errors++;
        end
        if (got.view_distance !== want.view_distance) begin
          $display("%0t: view_distance expected %0d actual %0d", $time, want.view_distance,
                   got.view_distance);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("agent_view_relevance_filter_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    avrf_pkg::avrf_out_t none;
    avrf_pkg::avrf_out_t fresh;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = avrf_pkg::CFG_CHECK_ENABLE;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    ready_pct = 100;
    ready_cnt = 0;
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    m_check = 1'b0; m_vmax = 23'd6144; m_vmin = 23'd1536; m_thr = 15'd307;
    m_half = 16'd16368; m_map = 23'd5120;
    pose_x = '0; pose_y = '0; pose_yaw = '0; pose_vd = '0; pose_valid = 1'b0;

    none = '0;
    fresh = '0;
    fresh.robot_known = 1'b1;
    fresh.view_distance = 23'd1536;
    // query before any update, then a still robot at the minimum view distance
    add_row(make_item(avrf_pkg::OP_QUERY, 1000, -1000, 0, 0, 0, 0, 0, 0), 1, none);
    add_row(make_item(avrf_pkg::OP_ROBOT, 0, 0, 0, 0, 0, 16384, 0, 0), 1, fresh);
    add_row(make_item(avrf_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, 1000, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, 1536, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, -1000, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, 0, 7100, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_ROBOT, 8388607, 8388607, 16384, 16384, 16384,
                      16384, 32767, 32767), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, -8388608, -8388608, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, 8388000, 8388000, -1, -1, -1, -1, -1, -1),
            0, none);
    add_row(make_item(avrf_pkg::OP_ROBOT, -8388608, -8388608, -16384, -16384, -16384,
                      -16384, -32768, -32768), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, -8388000, -8386000, 0, 0, 0, 0, 0, 0), 0, none);
    // full-scale negative quaternion, all four squares at their largest
    add_row(make_item(avrf_pkg::OP_ROBOT, 0, 0, -32768, -32768, -32768, -32768, 0, 0),
            0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, 0, 1000, 0, 0, 0, 0, 0, 0), 0, none);
    // gimbal lock and the all-zero quaternion
    add_row(make_item(avrf_pkg::OP_ROBOT, 0, 0, 0, 11585, 0, 11585, 300, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, 500, 500, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_ROBOT, 100, -100, 0, 0, 0, 0, 0, 307), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, -500, -100, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_ROBOT, 0, 0, 0, 0, 16384, 0, 150, 150), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, -1000, 10, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, 1000, 10, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(avrf_pkg::OP_QUERY, 0, -7000, 0, 0, 0, 0, 0, 0), 0, none);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_regs(1'b1, 23'd6144, 23'd1536, 23'd307, 23'd16368, 23'd5120);
    foreach (directed_rows[i])
      send_word(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_regs(1'b0, 23'd6144, 23'd1536, 23'd307, 23'd16368, 23'd5120);
        1: set_regs(1'b1, 23'd8388607, 23'd0, 23'd1, 23'd32768, 23'd8388607);
        2: set_regs(1'b1, 23'd20000, 23'd3000, 23'd0, 23'd0, 23'd0);
        3: set_regs(1'b1, 23'd4000, 23'd9000, 23'd32767, 23'd8000, 23'd2000);
        default: set_regs(1'b1, 23'($urandom_range(2000, 40000)),
                          23'($urandom_range(0, 2000)), 23'($urandom_range(1, 32767)),
                          23'($urandom_range(0, 32768)), 23'($urandom_range(0, 30000)));
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_word(random_item(), 0, none);
    end

    req_ch.valid <= 1'b0;
    wait (due_results.size() == 0);
    repeat (150) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("agent_view_relevance_filter_unit_tb: clean");
    end else begin
      $display("agent_view_relevance_filter_unit_tb: errors");
    end
    $finish;
  end

endmodule
